// ===== hw/rtl/ggv_pkg.sv =====
`timescale 1ns / 1ps
package ggv_pkg;

    localparam int ANG_W = 24;
    localparam int XV_W  = 32;
    localparam int XR_W  = 24;
    localparam int SQ_W  = 34;
    localparam int DIST_W = 17;
    localparam int OUT_W = 18;

    typedef logic signed [ANG_W-1:0] t_ang;

    localparam logic [2:0] REG_GOAL_X        = 3'd0;
    localparam logic [2:0] REG_GOAL_Y        = 3'd1;
    localparam logic [2:0] REG_GAIN_LINEAR   = 3'd2;
    localparam logic [2:0] REG_GAIN_ANGULAR  = 3'd3;
    localparam logic [2:0] REG_STOP_DISTANCE = 3'd4;

    localparam logic signed [25:0] ANG_PI      = 26'sd3294199;
    localparam logic signed [25:0] ANG_TWO_PI  = 26'sd6588398;
    localparam logic signed [25:0] ANG_HALF_PI = 26'sd1647099;
    localparam logic signed [XR_W-1:0] COS_START = 24'sd636751;
    localparam logic signed [21:0] ONE_Q20 = 22'sd1048576;

    // Arctangent of 2^-i in Q.20 radians.
    localparam t_ang ATAN_Q20 [24] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
        24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
        24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
        24'sd256,    24'sd128,    24'sd64,     24'sd32,
        24'sd16,     24'sd8,      24'sd4,      24'sd2,
        24'sd1,      24'sd0,      24'sd0,      24'sd0
    };

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [23:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > 24'sd131071) begin
            r = 18'sd131071;
        end else if (v < -24'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/go_to_goal_velocity_controller.sv =====
`timescale 1ns / 1ps
// Go-to-goal velocity controller.
// Input channel: i_in_valid with pose fields; o_in_stall holds the pose off.
// A pose transfers at an edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid with linear_speed and turn_rate; the receiver
// stalls it with i_out_stall. A pose at or inside the stop distance gives
// no output at all.
// Configuration: i_cfg_valid with index and data; o_cfg_ready is always high.
// Write registers only while no pose is in flight.
// Throughput is one pose per cycle while the output is not stalled. The
// pipeline has three setup stages, seventeen square-root cells, the
// vectoring CORDIC chain, two angle stages, the rotation CORDIC chain and
// three stages of multiply, round and saturate.
// While the output holds a result and the receiver stalls, the whole chain
// freezes and o_in_stall is raised; nothing is dropped.
// Reset empties the pipeline and loads the default goal, gains and stop
// distance.
module go_to_goal_velocity_controller #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [15:0] i_heading,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_linear_speed,
    output logic signed [17:0] o_turn_rate,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam int N      = CORDIC_STAGES;
    localparam int SQ_W   = ggv_pkg::SQ_W;
    localparam int XV_W   = ggv_pkg::XV_W;
    localparam int XR_W   = ggv_pkg::XR_W;
    localparam int DIST_W = ggv_pkg::DIST_W;
    localparam int SQ_TAG = 2 * XV_W + ggv_pkg::ANG_W + 16;
    localparam int VT_TAG = DIST_W + 16;
    localparam int RT_TAG = DIST_W + ggv_pkg::OUT_W + 1;

    logic               adv;
    logic signed [15:0] r_goal_x, r_goal_y;
    logic [11:0]        r_gain_lin, r_gain_ang;
    logic [15:0]        r_stop;

    assign adv         = !o_out_valid || !i_out_stall;
    assign o_in_stall  = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x   <= 16'sd5673;
            r_goal_y   <= 16'sd5673;
            r_gain_lin <= 12'd256;
            r_gain_ang <= 12'd512;
            r_stop     <= 16'd51;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ggv_pkg::REG_GOAL_X:        r_goal_x   <= i_cfg_data;
                ggv_pkg::REG_GOAL_Y:        r_goal_y   <= i_cfg_data;
                ggv_pkg::REG_GAIN_LINEAR:   r_gain_lin <= i_cfg_data[11:0];
                ggv_pkg::REG_GAIN_ANGULAR:  r_gain_ang <= i_cfg_data[11:0];
                ggv_pkg::REG_STOP_DISTANCE: r_stop     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Setup stages: differences, squares with pre-rotation, sum.
    logic               r_v1, r_v2, r_v3;
    logic signed [16:0] r_dx, r_dy;
    logic signed [15:0] r_head1, r_head2, r_head3;
    logic [31:0]        r_sqx, r_sqy;
    logic signed [XV_W-1:0] r_vx2, r_vy2, r_vx3, r_vy3, n_vx, n_vy;
    ggv_pkg::t_ang      r_vz2, r_vz3, n_vz;
    logic [SQ_W-1:0]    r_sum;
    logic signed [33:0] sqx_full, sqy_full;
    logic signed [XV_W-1:0] x12, y12;

    always_comb begin
        sqx_full = r_dx * r_dx;
        sqy_full = r_dy * r_dy;
        x12 = {{(XV_W-29){r_dx[16]}}, r_dx, 12'b0};
        y12 = {{(XV_W-29){r_dy[16]}}, r_dy, 12'b0};
        n_vx = x12;
        n_vy = y12;
        n_vz = '0;
        if (r_dx[16]) begin
            if (!r_dy[16]) begin
                n_vx = y12;
                n_vy = -x12;
                n_vz = ggv_pkg::ANG_HALF_PI[ggv_pkg::ANG_W-1:0];
            end else begin
                n_vx = -y12;
                n_vy = x12;
                n_vz = -ggv_pkg::ANG_HALF_PI[ggv_pkg::ANG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx    <= 17'(r_goal_x) - 17'(i_pose_x);
            r_dy    <= 17'(r_goal_y) - 17'(i_pose_y);
            r_head1 <= i_heading;
            r_sqx   <= sqx_full[31:0];
            r_sqy   <= sqy_full[31:0];
            r_vx2   <= n_vx;
            r_vy2   <= n_vy;
            r_vz2   <= n_vz;
            r_head2 <= r_head1;
            r_sum   <= SQ_W'(r_sqx) + SQ_W'(r_sqy);
            r_vx3   <= r_vx2;
            r_vy3   <= r_vy2;
            r_vz3   <= r_vz2;
            r_head3 <= r_head2;
        end
    end

    // Square-root chain.
    logic              sq_v [0:17];
    logic [SQ_W-1:0]   sq_n [0:17];
    logic [SQ_W-1:0]   sq_r [0:17];
    logic [SQ_TAG-1:0] sq_t [0:17];

    assign sq_v[0] = r_v3;
    assign sq_n[0] = r_sum;
    assign sq_r[0] = '0;
    assign sq_t[0] = {r_vx3, r_vy3, r_vz3, r_head3};

    for (genvar j = 0; j < 17; j++) begin : g_sqrt
        ggv_sqrt_cell #(.K(16 - j), .TAG_W(SQ_TAG)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_valid(sq_v[j]), .i_n(sq_n[j]), .i_r(sq_r[j]), .i_tag(sq_t[j]),
            .o_valid(sq_v[j+1]), .o_n(sq_n[j+1]), .o_r(sq_r[j+1]),
            .o_tag(sq_t[j+1])
        );
    end

    // Vectoring chain for the bearing.
    logic                   vc_v [0:N];
    logic signed [XV_W-1:0] vc_x [0:N];
    logic signed [XV_W-1:0] vc_y [0:N];
    ggv_pkg::t_ang          vc_z [0:N];
    logic [VT_TAG-1:0]      vc_t [0:N];

    assign vc_v[0] = sq_v[17];
    assign vc_x[0] = sq_t[17][SQ_TAG-1 -: XV_W];
    assign vc_y[0] = sq_t[17][SQ_TAG-1-XV_W -: XV_W];
    assign vc_z[0] = sq_t[17][16 +: ggv_pkg::ANG_W];
    assign vc_t[0] = {sq_r[17][DIST_W-1:0], sq_t[17][15:0]};

    for (genvar i = 0; i < N; i++) begin : g_vec
        ggv_cordic_cell #(.SHIFT(i), .VECTORING(1'b1), .XY_W(XV_W), .TAG_W(VT_TAG)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_valid(vc_v[i]), .i_x(vc_x[i]), .i_y(vc_y[i]), .i_z(vc_z[i]),
            .i_tag(vc_t[i]),
            .o_valid(vc_v[i+1]), .o_x(vc_x[i+1]), .o_y(vc_y[i+1]), .o_z(vc_z[i+1]),
            .o_tag(vc_t[i+1])
        );
    end

    // Heading error and its wrap into (-pi, pi].
    logic                r_ve, r_vp;
    logic signed [22:0]  r_err, n_err;
    logic [DIST_W-1:0]   r_dist_e, r_dist_p;
    logic signed [25:0]  err0, e1;
    logic signed [25:0]  hd;

    always_comb begin
        hd   = {{2{vc_t[N][15]}}, vc_t[N][15:0], 8'b0};
        err0 = 26'(vc_z[N]) - hd;
        if (err0 > ggv_pkg::ANG_PI) begin
            e1 = err0 - ggv_pkg::ANG_TWO_PI;
            if (e1 > ggv_pkg::ANG_PI) begin
                e1 = e1 - ggv_pkg::ANG_TWO_PI;
            end
        end else if (err0 <= -ggv_pkg::ANG_PI) begin
            e1 = err0 + ggv_pkg::ANG_TWO_PI;
            if (e1 <= -ggv_pkg::ANG_PI) begin
                e1 = e1 + ggv_pkg::ANG_TWO_PI;
            end
        end else begin
            e1 = err0;
        end
        n_err = e1[22:0];
    end

    // Turn rate and quadrant fold for the cosine.
    logic signed [35:0]  ang_prod;
    logic signed [36:0]  ang_rnd;
    logic signed [17:0]  r_turn_p;
    ggv_pkg::t_ang       r_rz, n_rz;
    logic                r_neg, n_neg;
    logic signed [25:0]  ez;

    always_comb begin
        ang_prod = $signed({1'b0, r_gain_ang}) * r_err;
        ang_rnd  = 37'(ang_prod) + 37'sd32768;
        ez       = 26'(r_err);
        n_neg    = 1'b0;
        if (ez > ggv_pkg::ANG_HALF_PI) begin
            ez    = ez - ggv_pkg::ANG_PI;
            n_neg = 1'b1;
        end else if (ez < -ggv_pkg::ANG_HALF_PI) begin
            ez    = ez + ggv_pkg::ANG_PI;
            n_neg = 1'b1;
        end
        n_rz = ez[ggv_pkg::ANG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
            r_vp <= 1'b0;
        end else if (adv) begin
            r_ve <= vc_v[N];
            r_vp <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_err    <= n_err;
            r_dist_e <= vc_t[N][VT_TAG-1 -: DIST_W];
            r_turn_p <= ggv_pkg::sat_out(24'(ang_rnd >>> 16));
            r_rz     <= n_rz;
            r_neg    <= n_neg;
            r_dist_p <= r_dist_e;
        end
    end

    // Rotation chain for the cosine.
    logic                   rc_v [0:N];
    logic signed [XR_W-1:0] rc_x [0:N];
    logic signed [XR_W-1:0] rc_y [0:N];
    ggv_pkg::t_ang          rc_z [0:N];
    logic [RT_TAG-1:0]      rc_t [0:N];

    assign rc_v[0] = r_vp;
    assign rc_x[0] = ggv_pkg::COS_START;
    assign rc_y[0] = '0;
    assign rc_z[0] = r_rz;
    assign rc_t[0] = {r_dist_p, r_turn_p, r_neg};

    for (genvar i = 0; i < N; i++) begin : g_rot
        ggv_cordic_cell #(.SHIFT(i), .VECTORING(1'b0), .XY_W(XR_W), .TAG_W(RT_TAG)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_valid(rc_v[i]), .i_x(rc_x[i]), .i_y(rc_y[i]), .i_z(rc_z[i]),
            .i_tag(rc_t[i]),
            .o_valid(rc_v[i+1]), .o_x(rc_x[i+1]), .o_y(rc_y[i+1]), .o_z(rc_z[i+1]),
            .o_tag(rc_t[i+1])
        );
    end

    // Clamp, multiply, round and saturate.
    logic                r_vc, r_vm, r_out_valid;
    logic                r_keep_c, r_keep_m;
    logic signed [21:0]  r_cos, n_cos;
    logic [28:0]         r_p1;
    logic signed [51:0]  r_prod;
    logic signed [17:0]  r_turn_c, r_turn_m;
    logic signed [17:0]  r_lin_o, r_turn_o;
    logic signed [22:0]  cx;
    logic signed [52:0]  lin_rnd;
    logic [DIST_W-1:0]   dist_r;

    always_comb begin
        dist_r = rc_t[N][RT_TAG-1 -: DIST_W];
        if (rc_x[N] > 24'sd1048576) begin
            cx = 23'sd1048576;
        end else if (rc_x[N] < -24'sd1048576) begin
            cx = -23'sd1048576;
        end else begin
            cx = rc_x[N][22:0];
        end
        n_cos   = rc_t[N][0] ? -cx[21:0] : cx[21:0];
        lin_rnd = 53'(r_prod) + 53'sd134217728;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= 1'b0;
            r_vm        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vc        <= rc_v[N];
            r_vm        <= r_vc;
            r_out_valid <= r_vm && r_keep_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cos    <= n_cos;
            r_p1     <= 29'(r_gain_lin) * 29'(dist_r);
            r_keep_c <= 16'(dist_r) > r_stop || dist_r[16];
            r_turn_c <= rc_t[N][1 +: 18];
            r_prod   <= $signed({1'b0, r_p1}) * r_cos;
            r_keep_m <= r_keep_c;
            r_turn_m <= r_turn_c;
            r_lin_o  <= ggv_pkg::sat_out(lin_rnd[51:28]);
            r_turn_o <= r_turn_m;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_linear_speed = r_lin_o;
    assign o_turn_rate    = r_turn_o;

    property p_freeze;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall;
    endproperty
    a_freeze: assert property (p_freeze) else $error("pipeline moved under stall");

    property p_err_wrapped;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_ve |-> (26'(r_err) > -ggv_pkg::ANG_PI) && (26'(r_err) <= ggv_pkg::ANG_PI);
    endproperty
    a_err_wrapped: assert property (p_err_wrapped) else $error("heading error not wrapped");

    property p_cos_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_vc |-> (r_cos <= ggv_pkg::ONE_Q20) && (r_cos >= -ggv_pkg::ONE_Q20);
    endproperty
    a_cos_range: assert property (p_cos_range) else $error("cosine out of range");

    property p_enter;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1;
    endproperty
    a_enter: assert property (p_enter) else $error("accepted pose lost at entry");

endmodule

// ===== hw/rtl/ggv_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One result bit of the digit-by-digit integer square root.
module ggv_sqrt_cell #(
    parameter int K     = 16,
    parameter int TAG_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [ggv_pkg::SQ_W-1:0] i_n,
    input  logic [ggv_pkg::SQ_W-1:0] i_r,
    input  logic [TAG_W-1:0]        i_tag,
    output logic                    o_valid,
    output logic [ggv_pkg::SQ_W-1:0] o_n,
    output logic [ggv_pkg::SQ_W-1:0] o_r,
    output logic [TAG_W-1:0]        o_tag
);
    localparam int W = ggv_pkg::SQ_W;
    localparam logic [W-1:0] B = W'(1) << (2 * K);

    logic         r_valid;
    logic [W-1:0] r_n, r_r;
    logic [TAG_W-1:0] r_tag;
    logic [W:0]   trial;
    logic [W-1:0] n_n, n_r;

    always_comb begin
        trial = {1'b0, i_r} + {1'b0, B};
        if ({1'b0, i_n} >= trial) begin
            n_n = i_n - trial[W-1:0];
            n_r = (i_r >> 1) + B;
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= n_n;
            r_r   <= n_r;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_r     = r_r;
    assign o_tag   = r_tag;
endmodule

// ===== hw/rtl/ggv_cordic_cell.sv =====
`timescale 1ns / 1ps
// One micro-rotation; vectoring drives y to zero, rotation drives z to zero.
module ggv_cordic_cell #(
    parameter int SHIFT     = 0,
    parameter bit VECTORING = 1'b1,
    parameter int XY_W      = 32,
    parameter int TAG_W     = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  ggv_pkg::t_ang          i_z,
    input  logic [TAG_W-1:0]       i_tag,
    output logic                   o_valid,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output ggv_pkg::t_ang          o_z,
    output logic [TAG_W-1:0]       o_tag
);
    localparam ggv_pkg::t_ang ATAN = ggv_pkg::ATAN_Q20[SHIFT];

    logic                   r_valid;
    logic signed [XY_W-1:0] r_x, r_y, n_x, n_y, xs, ys;
    ggv_pkg::t_ang          r_z, n_z;
    logic [TAG_W-1:0]       r_tag;
    logic                   pos;

    always_comb begin
        xs  = i_x >>> SHIFT;
        ys  = i_y >>> SHIFT;
        pos = VECTORING ? !i_y[XY_W-1] : !i_z[ggv_pkg::ANG_W-1];
        if (VECTORING == pos) begin
            // Vectoring with y >= 0, or rotation with z < 0.
            n_x = i_x + ys;
            n_y = i_y - xs;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
        end
        n_z = pos ? (VECTORING ? i_z + ATAN : i_z - ATAN)
                  : (VECTORING ? i_z - ATAN : i_z + ATAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

    localparam int PIPE_DELAY = 2 * 16 + 25;
    localparam int SETTLE     = PIPE_DELAY + 20;
    localparam int CYCLE_CAP  = 400000;

    typedef struct {
        logic signed [17:0] lin;
        logic signed [17:0] turn;
    } t_speed_cmd;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_pose_x;
    logic signed [15:0] i_pose_y;
    logic signed [15:0] i_heading;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [17:0] o_linear_speed;
    logic signed [17:0] o_turn_rate;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    go_to_goal_velocity_controller i_dut (.*);

    // Local copy of the controller registers.
    logic signed [15:0] goal_x_q;
    logic signed [15:0] goal_y_q;
    logic [11:0]        gain_lin_q;
    logic [11:0]        gain_ang_q;
    logic [15:0]        stop_dist_q;

    t_speed_cmd pending_cmds[$];
    int         fail_count;
    int         poses_sent;
    int         cmds_seen;
    int         cfg_writes;
    int         cycle_count;
    int         out_hold;
    bit         calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint int_sqrt(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'd1 << 40;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint goal_bearing(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        x = dx * 4096;
        y = dy * 4096;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = ggv_pkg::ANG_HALF_PI;
            end else begin
                x = -y;
                y = t;
                z = -ggv_pkg::ANG_HALF_PI;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ggv_pkg::ATAN_Q20[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ggv_pkg::ATAN_Q20[i];
            end
        end
        return z;
    endfunction

    function automatic longint cos_q20(longint a);
        longint x, y, z, xs, ys;
        bit flip;
        x = ggv_pkg::COS_START;
        y = 0;
        z = a;
        flip = 1'b0;
        // Errors past a quarter turn are folded by half a turn and negated.
        if (z > ggv_pkg::ANG_HALF_PI) begin
            z = z - ggv_pkg::ANG_PI;
            flip = 1'b1;
        end else if (z < -ggv_pkg::ANG_HALF_PI) begin
            z = z + ggv_pkg::ANG_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ggv_pkg::ATAN_Q20[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ggv_pkg::ATAN_Q20[i];
            end
        end
        if (x > ggv_pkg::ONE_Q20) x = ggv_pkg::ONE_Q20;
        if (x < -ggv_pkg::ONE_Q20) x = -ggv_pkg::ONE_Q20;
        return flip ? -x : x;
    endfunction

    function automatic logic signed [17:0] clamp18(longint v);
        if (v > 131071) return 18'sd131071;
        if (v < -131072) return -18'sd131072;
        return v[17:0];
    endfunction

    function automatic bit compute_velocity_cmd(logic signed [15:0] px, logic signed [15:0] py,
                                                logic signed [15:0] hd, output t_speed_cmd cmd);
        longint dx, dy, span, err;
        dx = longint'(goal_x_q) - longint'(px);
        dy = longint'(goal_y_q) - longint'(py);
        span = int_sqrt(dx * dx + dy * dy);
        cmd.lin = '0;
        cmd.turn = '0;
        if (span <= longint'(stop_dist_q)) return 1'b0;
        err = goal_bearing(dx, dy) - longint'(hd) * 256;
        for (int k = 0; k < 4 && err > ggv_pkg::ANG_PI; k++) err = err - ggv_pkg::ANG_TWO_PI;
        for (int k = 0; k < 4 && err <= -ggv_pkg::ANG_PI; k++) err = err + ggv_pkg::ANG_TWO_PI;
        cmd.lin = clamp18((longint'(gain_lin_q) * span * cos_q20(err) + (64'sd1 <<< 27)) >>> 28);
        cmd.turn = clamp18((longint'(gain_ang_q) * err + (64'sd1 <<< 15)) >>> 16);
        return 1'b1;
    endfunction

    // Sends one pose, after a random gap unless calm, and records the command it should produce.
    task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] hd);
        int gap;
        t_speed_cmd cmd;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pose_x <= px;
        i_pose_y <= py;
        i_heading <= hd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        poses_sent++;
        if (compute_velocity_cmd(px, py, hd, cmd)) pending_cmds.push_back(cmd);
    endtask

    task automatic end_stream();
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_pipe();
        end_stream();
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            ggv_pkg::REG_GOAL_X:        goal_x_q = data;
            ggv_pkg::REG_GOAL_Y:        goal_y_q = data;
            ggv_pkg::REG_GAIN_LINEAR:   gain_lin_q = data[11:0];
            ggv_pkg::REG_GAIN_ANGULAR:  gain_ang_q = data[11:0];
            ggv_pkg::REG_STOP_DISTANCE: stop_dist_q = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_setup(logic [15:0] gx, logic [15:0] gy, logic [15:0] gl,
                              logic [15:0] ga, logic [15:0] sd);
        drain_pipe();
        write_reg(ggv_pkg::REG_GOAL_X, gx);
        write_reg(ggv_pkg::REG_GOAL_Y, gy);
        write_reg(ggv_pkg::REG_GAIN_LINEAR, gl);
        write_reg(ggv_pkg::REG_GAIN_ANGULAR, ga);
        write_reg(ggv_pkg::REG_STOP_DISTANCE, sd);
    endtask

    task automatic test_reset_defaults();
        // Pose on the goal, inside the stop radius, just outside it, and each quadrant.
        send_pose(16'sd5673, 16'sd5673, 16'sd0);
        send_pose(16'sd5700, 16'sd5650, 16'sd100);
        send_pose(16'sd5673 - 16'sd60, 16'sd5673, 16'sd0);
        send_pose(16'sd0, 16'sd0, 16'sd0);
        send_pose(16'sd10000, 16'sd0, 16'sd12868);
        send_pose(16'sd10000, 16'sd10000, -16'sd12868);
        send_pose(16'sd0, 16'sd10000, 16'sd6434);
        send_pose(16'sd5673, 16'sd0, -16'sd6434);
        send_pose(16'sd7000, 16'sd5673, 16'sd0);
        drain_pipe();
    endtask

    task automatic test_field_extremes();
        send_pose(-16'sd32768, -16'sd32768, -16'sd32768);
        send_pose(16'sd32767, 16'sd32767, 16'sd32767);
        send_pose(-16'sd32768, 16'sd32767, 16'sd0);
        send_pose(16'sd32767, -16'sd32768, 16'sd0);
        send_pose(16'sd0, 16'sd0, 16'sd32767);
        send_pose(16'sd0, 16'sd0, -16'sd32768);
        drain_pipe();
    endtask

    task automatic test_config_extremes();
        // Saturating gains and far goal, then zero gains, then unreachable stop distance.
        load_setup(16'h8000, 16'h7FFF, 16'h0FFF, 16'h0FFF, 16'h0000);
        send_pose(16'sd32767, -16'sd32768, 16'sd0);
        send_pose(16'sd32767, -16'sd32768, 16'sd12868);
        send_pose(-16'sd32767, 16'sd32767, 16'sd0);
        send_pose(-16'sd32768, 16'sd32766, -16'sd9000);
        load_setup(16'h7FFF, 16'h8000, 16'hF000, 16'hF000, 16'h0001);
        send_pose(16'sd0, 16'sd0, 16'sd1000);
        send_pose(16'sd32767, -16'sd32768, 16'sd0);
        send_pose(16'sd32766, -16'sd32768, 16'sd0);
        load_setup(16'h0000, 16'h0000, 16'h0100, 16'h0200, 16'hFFFF);
        send_pose(-16'sd32768, -16'sd32768, 16'sd0);
        send_pose(16'sd1000, 16'sd1000, 16'sd0);
        // Indexes past the register file are ignored.
        drain_pipe();
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'h0000);
        send_pose(-16'sd32768, -16'sd32768, 16'sd0);
        drain_pipe();
    endtask

    task automatic test_random_poses();
        logic signed [15:0] px, py;
        int n;
        for (int phase = 0; phase < 8; phase++) begin
            load_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       (phase % 2) ? 16'($urandom_range(0, 65535))
                                   : 16'($urandom_range(0, 3000)));
            calm = (phase == 3);
            n = 150;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) < 6) begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end else begin
                    // Poses near the goal exercise the stop boundary.
                    px = goal_x_q + 16'($signed($urandom_range(0, 4000)) - 2000);
                    py = goal_y_q + 16'($signed($urandom_range(0, 4000)) - 2000);
                end
                send_pose(px, py, 16'($urandom));
                if (phase == 5 && k == n / 2) begin
                    end_stream();
                    while (pending_cmds.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
            end
            calm = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_speed_cmd want;
        if (o_out_valid && !i_out_stall && i_rst_n) begin
            cmds_seen++;
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected command lin=%0d turn=%0d", $time,
                         o_linear_speed, o_turn_rate);
                fail_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_linear_speed !== want.lin) begin
                    $display("%0t: linear_speed expected %0d actual %0d", $time,
                             want.lin, o_linear_speed);
                    fail_count++;
                end
                if (o_turn_rate !== want.turn) begin
                    $display("%0t: turn_rate expected %0d actual %0d", $time,
                             want.turn, o_turn_rate);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure: a random hold after each transfer, none while calm.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall && i_rst_n) out_hold = calm ? 0 : $urandom_range(0, 12);
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        poses_sent = 0;
        cmds_seen = 0;
        cfg_writes = 0;
        cycle_count = 0;
        out_hold = 0;
        calm = 1'b0;
        goal_x_q = 16'sd5673;
        goal_y_q = 16'sd5673;
        gain_lin_q = 12'd256;
        gain_ang_q = 12'd512;
        stop_dist_q = 16'd51;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_pose_x <= '0;
        i_pose_y <= '0;
        i_heading <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_config_extremes();
        test_random_poses();

        drain_pipe();
        $display("Covered %0d poses and %0d register writes, with default, extreme and",
                 poses_sent, cfg_writes);
        $display("random setups; %0d velocity commands were checked, %0d mismatches.",
                 cmds_seen, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/ggv_pkg.sv
hw/rtl/ggv_sqrt_cell.sv
hw/rtl/ggv_cordic_cell.sv
hw/rtl/go_to_goal_velocity_controller.sv
tb/tb.sv
